// File: rtl/core/kf_pkg.sv
// shared types, register codes and a helper function for the scalar kalman filter
// used by kf_div and scalar_kalman_filter; depends on nothing else

package kf_pkg;

    // register index codes on the config port
    localparam logic [2:0] REG_INIT_EST  = 3'd0;
    localparam logic [2:0] REG_INIT_COV  = 3'd1;
    localparam logic [2:0] REG_PROC_NOISE = 3'd2;
    localparam logic [2:0] REG_MEAS_NOISE = 3'd3;
    localparam logic [2:0] REG_ADAPT_EN  = 3'd4;

    // constant divisors for the noise adaptation (6/5 grow, 19/20 shrink)
    localparam logic [4:0] GROW_DIV   = 5'd5;
    localparam logic [4:0] SHRINK_DIV = 5'd20;

    // divider status between the sequencer and the gain divider
    typedef struct packed {
        logic busy;
        logic done;
    } kf_div_stat_t;

    // one byte of long division by a small constant
    typedef struct packed {
        logic [7:0] quo;
        logic [4:0] rem;
    } cdiv_step_t;

    function automatic cdiv_step_t cdiv_step(
        input logic [4:0] rem_in,
        input logic [7:0] bits_in,
        input logic [4:0] divisor
    );
        cdiv_step_t r;
        logic [5:0] acc;
        r.quo = 8'h00;
        r.rem = rem_in;
        for (int i = 7; i >= 0; i--)
        begin
            acc = {r.rem, bits_in[i]};
            if (acc >= {1'b0, divisor})
            begin
                acc = acc - {1'b0, divisor};
                r.quo[i] = 1'b1;
            end
            r.rem = acc[4:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/kf_div.sv
// radix-2 restoring divider for the kalman gain, one quotient bit per cycle
// gives num/den in Q0.FRAC_BITS for num < den; uses kf_pkg

module kf_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DATA_WIDTH-1:0]   num,
    input  logic [DATA_WIDTH:0]     den,
    output kf_pkg::kf_div_stat_t    stat,
    output logic [FRAC_BITS-1:0]    quo
);

    localparam int CNT_W = $clog2(FRAC_BITS);

    logic [DATA_WIDTH:0]   rem_reg;
    logic [DATA_WIDTH:0]   den_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    logic [DATA_WIDTH+1:0] rem_sh;
    logic [DATA_WIDTH+1:0] rem_sub;
    logic                  fits;
    logic                  last;

    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign last    = (cnt_reg == CNT_W'(FRAC_BITS - 1));

    assign quo       = {quo_reg[FRAC_BITS-2:0], fits};
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DATA_WIDTH:0] : rem_sh[DATA_WIDTH:0];
            quo_reg <= quo;
        end
    end

endmodule

// File: rtl/core/scalar_kalman_filter.sv
// scalar kalman filter top level: config registers, sequencer, shared multiplier
// an input runs through the predict, setup, divide, multiply and wrap states to the result;
// the divide is skipped at zero noise and adaptation steps come first when enabled; restart
// goes straight to the output; one item at a time; the gain divider gives one quotient bit per cycle
// the result waits in an output register, the next input is taken meanwhile
// async active-low reset loads the state and config registers with their reset values

module scalar_kalman_filter #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // measurement, control_offset (low bits first)
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    // restart
    input  logic                              s_tuser,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // estimate, covariance, gain, noise_in_use (low bits first)
    output logic [((3*DATA_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] m_tdata,
    // config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [((DATA_WIDTH > 32) ? 6 : 5)-1:0] paddr,
    input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                              pready
);

    localparam int DW     = DATA_WIDTH;
    localparam int FB     = FRAC_BITS;
    localparam int PDW    = (DW > 32) ? 64 : 32;
    localparam int ASH    = (DW > 32) ? 3 : 2;
    localparam int AW     = ASH + 3;
    localparam int OUT_TW = ((3*DW+FB+1+7)/8)*8;
    localparam int PW     = DW + FB + 1;
    localparam int NSTEPS = (DW + 5 + 7) / 8;
    localparam int CW     = NSTEPS * 8;
    localparam int CCW    = $clog2(NSTEPS + 1);

    localparam logic [DW-1:0] RST_COV   = DW'(64'd1 << FB);
    localparam logic [DW-1:0] RST_Q     = DW'(((64'd1 << FB) + 64'd500) / 64'd1000);
    localparam logic [DW-1:0] RST_R     = DW'(((64'd1 << FB) + 64'd5) / 64'd10);
    localparam logic [DW-1:0] HALF_Q    = DW'(64'd1 << (FB - 1));
    localparam logic [CW-1:0] TEN_Q     = CW'(64'd10 << FB);
    localparam logic [CW-1:0] R_FLOOR   = CW'(((64'd1 << FB) + 64'd50) / 64'd100);
    localparam logic [FB:0]   GAIN_ONE  = {1'b1, {FB{1'b0}}};
    localparam logic [DW-1:0] SMAX      = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN      = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADAPT,
        ST_ADAPT_FIX,
        ST_PREDICT,
        ST_SETUP,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_WRAP,
        ST_DONE
    } state_t;

    // config registers
    logic [DW-1:0] init_est_reg;
    logic [DW-1:0] init_cov_reg;
    logic [DW-1:0] proc_noise_reg;
    logic [DW-1:0] meas_noise_reg;
    logic          adapt_en_reg;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    // filter state
    state_t          state_reg;
    logic [DW-1:0]   est_reg;
    logic [DW-1:0]   cov_reg;
    logic [FB:0]     gain_reg;
    logic [DW-1:0]   noise_reg;
    logic            m_valid_reg;
    logic [OUT_TW-1:0] m_data_reg;
    logic [CCW-1:0]  ccnt_reg;

    // working registers
    logic [DW-1:0]   z_reg;
    logic [DW-1:0]   u_reg;
    logic [DW-1:0]   xp_reg;
    logic [DW-1:0]   pp_reg;
    logic [DW-1:0]   mag_reg;
    logic            neg_reg;
    logic [PW-1:0]   mul_reg;
    logic [CW-1:0]   cnum_reg;
    logic [CW-1:0]   cquo_reg;
    logic [4:0]      crem_reg;
    logic [4:0]      cdiv_reg;
    logic            grow_reg;

    logic                   in_fire;
    logic [DW-1:0]          s_z;
    logic [DW-1:0]          s_u;
    logic [DW:0]            d_diff;
    logic [DW-1:0]          d_mag;
    logic                   grow;
    logic [CW-1:0]          num6;
    logic [CW-1:0]          num19;
    kf_pkg::cdiv_step_t     cstep;
    logic [DW:0]            xp_sum;
    logic [DW:0]            pp_sum;
    logic [DW:0]            res;
    logic [DW-1:0]          mul_a;
    logic [FB:0]            mul_b;
    logic [DW-1:0]          prod;
    logic [DW+1:0]          est_sum;
    logic                   est_ovf;
    logic                   div_start;
    kf_pkg::kf_div_stat_t   div_stat;
    logic [FB-1:0]          div_quo;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[AW-1:ASH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_est_reg   <= '0;
            init_cov_reg   <= RST_COV;
            proc_noise_reg <= RST_Q;
            meas_noise_reg <= RST_R;
            adapt_en_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                kf_pkg::REG_INIT_EST:   init_est_reg   <= pwdata[DW-1:0];
                kf_pkg::REG_INIT_COV:   init_cov_reg   <= pwdata[DW-1:0];
                kf_pkg::REG_PROC_NOISE: proc_noise_reg <= pwdata[DW-1:0];
                kf_pkg::REG_MEAS_NOISE: meas_noise_reg <= pwdata[DW-1:0];
                kf_pkg::REG_ADAPT_EN:   adapt_en_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            kf_pkg::REG_INIT_EST:   prdata = PDW'(init_est_reg);
            kf_pkg::REG_INIT_COV:   prdata = PDW'(init_cov_reg);
            kf_pkg::REG_PROC_NOISE: prdata = PDW'(proc_noise_reg);
            kf_pkg::REG_MEAS_NOISE: prdata = PDW'(meas_noise_reg);
            kf_pkg::REG_ADAPT_EN:   prdata = PDW'(adapt_en_reg);
            default:                prdata = '0;
        endcase
    end

    // stream handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign s_z = s_tdata[DW-1:0];
    assign s_u = s_tdata[2*DW-1:DW];

    // residual against the held estimate picks grow or shrink
    assign d_diff = {s_z[DW-1], s_z} - {est_reg[DW-1], est_reg};
    assign d_mag  = d_diff[DW] ? DW'(-d_diff) : d_diff[DW-1:0];
    assign grow   = d_mag > HALF_Q;
    assign num6   = (CW'(noise_reg) << 2) + (CW'(noise_reg) << 1);
    assign num19  = (CW'(noise_reg) << 4) + (CW'(noise_reg) << 1) + CW'(noise_reg);
    assign cstep  = kf_pkg::cdiv_step(crem_reg, cnum_reg[CW-1 -: 8], cdiv_reg);

    // prediction sums, saturated when registered, and the residual
    assign xp_sum = {est_reg[DW-1], est_reg} + {u_reg[DW-1], u_reg};
    assign pp_sum = {1'b0, cov_reg} + {1'b0, proc_noise_reg};
    assign res    = {z_reg[DW-1], z_reg} - {xp_reg[DW-1], xp_reg};

    // shared multiplier operands
    always_comb
    begin
        if (state_reg == ST_MUL_COV)
        begin
            mul_a = pp_reg;
            mul_b = GAIN_ONE - gain_reg;
        end
        else
        begin
            mul_a = mag_reg;
            mul_b = gain_reg;
        end
    end

    assign prod    = mul_reg[FB +: DW];
    assign est_sum = neg_reg ? ({{2{xp_reg[DW-1]}}, xp_reg} - {2'b00, prod})
                             : ({{2{xp_reg[DW-1]}}, xp_reg} + {2'b00, prod});
    assign est_ovf = (est_sum[DW+1] != est_sum[DW]) || (est_sum[DW] != est_sum[DW-1]);

    assign div_start = (state_reg == ST_SETUP) && (noise_reg != '0);

    kf_div #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pp_reg),
        .den   ({1'b0, pp_reg} + {1'b0, noise_reg}),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // sequencer, filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            est_reg     <= '0;
            cov_reg     <= RST_COV;
            gain_reg    <= '0;
            noise_reg   <= RST_R;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            ccnt_reg    <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    ccnt_reg <= '0;
                    if (in_fire)
                    begin
                        if (s_tuser)
                        begin
                            est_reg   <= init_est_reg;
                            cov_reg   <= init_cov_reg;
                            noise_reg <= meas_noise_reg;
                            gain_reg  <= '0;
                            state_reg <= ST_DONE;
                        end
                        else if (adapt_en_reg)
                        begin
                            state_reg <= ST_ADAPT;
                        end
                        else
                        begin
                            state_reg <= ST_PREDICT;
                        end
                    end
                end
                ST_ADAPT:
                begin
                    ccnt_reg <= ccnt_reg + CCW'(1);
                    if (ccnt_reg == CCW'(NSTEPS - 1))
                    begin
                        state_reg <= ST_ADAPT_FIX;
                    end
                end
                ST_ADAPT_FIX:
                begin
                    if (grow_reg)
                    begin
                        noise_reg <= (cquo_reg > TEN_Q) ? DW'(TEN_Q) : DW'(cquo_reg);
                    end
                    else
                    begin
                        noise_reg <= (cquo_reg < R_FLOOR) ? DW'(R_FLOOR) : DW'(cquo_reg);
                    end
                    state_reg <= ST_PREDICT;
                end
                ST_PREDICT:
                begin
                    state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    if (noise_reg == '0)
                    begin
                        gain_reg  <= (pp_reg != '0) ? GAIN_ONE : '0;
                        state_reg <= ST_MUL_EST;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        gain_reg  <= {1'b0, div_quo};
                        state_reg <= ST_MUL_EST;
                    end
                end
                ST_MUL_EST:
                begin
                    state_reg <= ST_MUL_COV;
                end
                ST_MUL_COV:
                begin
                    if (est_ovf)
                    begin
                        est_reg <= est_sum[DW+1] ? SMIN : SMAX;
                    end
                    else
                    begin
                        est_reg <= est_sum[DW-1:0];
                    end
                    state_reg <= ST_WRAP;
                end
                ST_WRAP:
                begin
                    cov_reg   <= prod;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OUT_TW'({noise_reg, gain_reg, cov_reg, est_reg});
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            z_reg    <= s_z;
            u_reg    <= s_u;
            grow_reg <= grow;
            cnum_reg <= grow ? num6 : num19;
            cdiv_reg <= grow ? kf_pkg::GROW_DIV : kf_pkg::SHRINK_DIV;
            crem_reg <= '0;
            cquo_reg <= '0;
        end
        if (state_reg == ST_ADAPT)
        begin
            cnum_reg <= {cnum_reg[CW-9:0], 8'h00};
            cquo_reg <= {cquo_reg[CW-9:0], cstep.quo};
            crem_reg <= cstep.rem;
        end
        if (state_reg == ST_PREDICT)
        begin
            if (xp_sum[DW] != xp_sum[DW-1])
            begin
                xp_reg <= xp_sum[DW] ? SMIN : SMAX;
            end
            else
            begin
                xp_reg <= xp_sum[DW-1:0];
            end
            pp_reg <= pp_sum[DW] ? {DW{1'b1}} : pp_sum[DW-1:0];
        end
        if (state_reg == ST_SETUP)
        begin
            neg_reg <= res[DW];
            mag_reg <= res[DW] ? DW'(-res) : res[DW-1:0];
        end
        if ((state_reg == ST_MUL_EST) || (state_reg == ST_MUL_COV))
        begin
            mul_reg <= PW'(mul_a) * PW'(mul_b);
        end
    end

    // checks
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("gain divider busy outside its state");

    a_gain_at_most_one: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg[FB] |-> (gain_reg[FB-1:0] == '0))
        else $error("gain above one");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input taken while an item is in work");

    a_cov_not_above_pred: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRAP) |=> (cov_reg <= $past(pp_reg)))
        else $error("posterior covariance above predicted covariance");

endmodule
